// ===== design/rvrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, action codes and memory request types for the range value replace table.
package rvrt_pkg;

  localparam int ARRAY_DEPTH  = 4096;
  localparam int SEGMENT_SIZE = 64;
  localparam int VALUE_COUNT  = 100;

  localparam int ACT_W = 2;
  localparam int POS_W = 13;
  localparam int VAL_W = 7;

  localparam int IDX_W       = $clog2(ARRAY_DEPTH);
  localparam int OFS_W       = $clog2(SEGMENT_SIZE);
  localparam int SEG_COUNT   = (ARRAY_DEPTH + SEGMENT_SIZE - 1) / SEGMENT_SIZE;
  localparam int SEG_W       = $clog2(SEG_COUNT);
  localparam int VIDX_W      = $clog2(VALUE_COUNT);
  localparam int RADDR_W     = SEG_W + VIDX_W;
  localparam int REMAP_DEPTH = SEG_COUNT << VIDX_W;
  localparam int CNT_MAX     = (SEGMENT_SIZE > VALUE_COUNT) ? SEGMENT_SIZE : VALUE_COUNT;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } elem_req_t;

  typedef struct packed {
    logic               we;
    logic [RADDR_W-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
    logic [RADDR_W-1:0] raddr;
  } remap_req_t;

  function automatic logic value_ok(input logic [VAL_W-1:0] v);
    return (v != '0) && (v <= VAL_W'(VALUE_COUNT));
  endfunction

endpackage

// ===== design/rvrt_elem_mem.sv =====
`timescale 1ns / 1ps
// Element store: one write port, one registered read port.
module rvrt_elem_mem (
  input  logic                        clk,
  input  rvrt_pkg::elem_req_t         req,
  output logic [rvrt_pkg::VAL_W-1:0]  rdata
);
  import rvrt_pkg::*;

  logic [VAL_W-1:0] mem_r [ARRAY_DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rvrt_remap_mem.sv =====
`timescale 1ns / 1ps
// Per-segment remap tables: one write port, one registered read port.
module rvrt_remap_mem (
  input  logic                        clk,
  input  rvrt_pkg::remap_req_t        req,
  output logic [rvrt_pkg::VAL_W-1:0]  rdata
);
  import rvrt_pkg::*;

  logic [VAL_W-1:0] mem_r [REMAP_DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rvrt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: clearing pass, remap passes, segment folds and element reads.
module rvrt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rvrt_pkg::ACT_W-1:0]  in_action,
  input  logic [rvrt_pkg::POS_W-1:0]  in_first_pos,
  input  logic [rvrt_pkg::POS_W-1:0]  in_last_pos,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_match_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_replace_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_load_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rvrt_pkg::VAL_W-1:0]  out_read_value,
  input  logic                        cfg_wr_en,
  input  logic [rvrt_pkg::POS_W-1:0]  cfg_wr_data,
  output rvrt_pkg::elem_req_t         elem_req,
  input  logic [rvrt_pkg::VAL_W-1:0]  elem_rdata,
  output rvrt_pkg::remap_req_t        remap_req,
  input  logic [rvrt_pkg::VAL_W-1:0]  remap_rdata
);
  import rvrt_pkg::*;

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_MID        = 4'd2;
  localparam logic [3:0] S_MID_DRAIN  = 4'd3;
  localparam logic [3:0] S_FOLD       = 4'd4;
  localparam logic [3:0] S_FOLD_DRAIN = 4'd5;
  localparam logic [3:0] S_IDENT      = 4'd6;
  localparam logic [3:0] S_RD_A       = 4'd7;
  localparam logic [3:0] S_RD_B       = 4'd8;
  localparam logic [3:0] S_RD_C       = 4'd9;
  localparam logic [3:0] S_RD_OUT     = 4'd10;

  logic [3:0]         state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SEG_W-1:0]   cur_seg_r;
  logic [SEG_W-1:0]   ms_r;
  logic [SEG_W-1:0]   segr_r;
  logic               second_r;
  logic [POS_W-1:0]   len_r;
  logic [IDX_W-1:0]   lo_r;
  logic [IDX_W-1:0]   hi_r;
  logic [VAL_W-1:0]   match_r;
  logic [VAL_W-1:0]   repl_r;
  logic [VAL_W-1:0]   lval_r;
  logic               load_r;
  logic               edit_r;
  logic               f1_v_r;
  logic [IDX_W-1:0]   f1_idx_r;
  logic               f2_v_r;
  logic [IDX_W-1:0]   f2_idx_r;
  logic [VAL_W-1:0]   f2_val_r;
  logic               f2_ok_r;
  logic               m_v_r;
  logic [RADDR_W-1:0] m_addr_r;
  logic [VAL_W-1:0]   rd_val_r;
  logic               rd_ok_r;
  logic [VAL_W-1:0]   hold_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;

  logic [POS_W-1:0]   use_len;
  logic [POS_W-1:0]   last_c;
  logic [POS_W-1:0]   first_m1;
  logic [POS_W-1:0]   last_m1;
  logic [IDX_W-1:0]   fidx;
  logic [IDX_W-1:0]   lidx;
  logic [SEG_W-1:0]   seg_f;
  logic [SEG_W-1:0]   seg_l;
  logic               pos_ok;
  logic               rng_ok;
  logic [VAL_W-1:0]   mapped;
  logic [VAL_W-1:0]   fold_out;
  logic               in_rng;

  assign use_len  = (len_r > POS_W'(ARRAY_DEPTH)) ? POS_W'(ARRAY_DEPTH) : len_r;
  assign last_c   = (in_last_pos > use_len) ? use_len : in_last_pos;
  assign first_m1 = in_first_pos - POS_W'(1);
  assign last_m1  = last_c - POS_W'(1);
  assign fidx     = first_m1[IDX_W-1:0];
  assign lidx     = last_m1[IDX_W-1:0];
  assign seg_f    = fidx[IDX_W-1:OFS_W];
  assign seg_l    = lidx[IDX_W-1:OFS_W];
  assign pos_ok   = (in_first_pos != '0) && (in_first_pos <= use_len);
  assign rng_ok   = (in_first_pos != '0) && (in_first_pos <= last_c) &&
                    value_ok(in_match_value) && value_ok(in_replace_value);

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  always_comb begin
    mapped   = f2_ok_r ? remap_rdata : f2_val_r;
    in_rng   = edit_r && (f2_idx_r >= lo_r) && (f2_idx_r <= hi_r);
    fold_out = mapped;
    if (load_r && (f2_idx_r == lo_r)) begin
      fold_out = lval_r;
    end else if (in_rng && (mapped == match_r)) begin
      fold_out = repl_r;
    end
  end

  always_comb begin
    elem_req.we    = f2_v_r;
    elem_req.waddr = f2_idx_r;
    elem_req.wdata = fold_out;
    elem_req.raddr = (state_r == S_FOLD) ? {cur_seg_r, cnt_r[OFS_W-1:0]} : lo_r;
  end

  always_comb begin
    remap_req.raddr = (state_r == S_MID) ? {ms_r, cnt_r[VIDX_W-1:0]} :
                      {cur_seg_r, VIDX_W'(elem_rdata - VAL_W'(1))};
    remap_req.we    = 1'b0;
    remap_req.waddr = m_addr_r;
    remap_req.wdata = repl_r;
    if ((state_r == S_CLEAR) || (state_r == S_IDENT)) begin
      remap_req.we    = 1'b1;
      remap_req.waddr = {cur_seg_r, cnt_r[VIDX_W-1:0]};
      remap_req.wdata = VAL_W'(cnt_r + CNT_W'(1));
    end else if (m_v_r && (remap_rdata == match_r)) begin
      remap_req.we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    f1_idx_r <= {cur_seg_r, cnt_r[OFS_W-1:0]};
    f2_idx_r <= f1_idx_r;
    f2_val_r <= elem_rdata;
    f2_ok_r  <= value_ok(elem_rdata);
    m_addr_r <= {ms_r, cnt_r[VIDX_W-1:0]};
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      cur_seg_r   <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      m_v_r       <= 1'b0;
      second_r    <= 1'b0;
      load_r      <= 1'b0;
      edit_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      f1_v_r <= (state_r == S_FOLD);
      f2_v_r <= f1_v_r;
      m_v_r  <= (state_r == S_MID);
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VALUE_COUNT - 1)) begin
            cnt_r <= '0;
            if (cur_seg_r == SEG_W'(SEG_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              cur_seg_r <= cur_seg_r + SEG_W'(1);
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            lo_r      <= fidx;
            hi_r      <= lidx;
            match_r   <= in_match_value;
            repl_r    <= in_replace_value;
            lval_r    <= in_load_value;
            segr_r    <= seg_l;
            cur_seg_r <= seg_f;
            cnt_r     <= '0;
            load_r    <= 1'b0;
            edit_r    <= 1'b0;
            second_r  <= 1'b0;
            unique case (in_action)
              ACT_LOAD: begin
                if (pos_ok && value_ok(in_load_value)) begin
                  load_r  <= 1'b1;
                  state_r <= S_FOLD;
                end
              end
              ACT_REPLACE: begin
                if (rng_ok) begin
                  edit_r <= 1'b1;
                  if (seg_f == seg_l) begin
                    state_r <= S_FOLD;
                  end else if ((seg_l - seg_f) > SEG_W'(1)) begin
                    second_r <= 1'b1;
                    ms_r     <= seg_f + SEG_W'(1);
                    state_r  <= S_MID;
                  end else begin
                    second_r <= 1'b1;
                    state_r  <= S_FOLD;
                  end
                end
              end
              ACT_READ: begin
                if (pos_ok) begin
                  state_r <= S_RD_A;
                end else begin
                  hold_r  <= '0;
                  state_r <= S_RD_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_MID: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VALUE_COUNT - 1)) begin
            cnt_r <= '0;
            if (ms_r == segr_r - SEG_W'(1)) begin
              state_r <= S_MID_DRAIN;
            end else begin
              ms_r <= ms_r + SEG_W'(1);
            end
          end
        end
        S_MID_DRAIN: begin
          cnt_r   <= '0;
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SEGMENT_SIZE - 1)) begin
            state_r <= S_FOLD_DRAIN;
          end
        end
        S_FOLD_DRAIN: begin
          if (!f1_v_r && !f2_v_r) begin
            cnt_r   <= '0;
            state_r <= S_IDENT;
          end
        end
        S_IDENT: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VALUE_COUNT - 1)) begin
            cnt_r <= '0;
            if (second_r) begin
              second_r  <= 1'b0;
              cur_seg_r <= segr_r;
              state_r   <= S_FOLD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          rd_val_r <= elem_rdata;
          rd_ok_r  <= value_ok(elem_rdata);
          state_r  <= S_RD_C;
        end
        S_RD_C: begin
          hold_r  <= rd_ok_r ? remap_rdata : rd_val_r;
          state_r <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= hold_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/range_value_replace_table.sv =====
`timescale 1ns / 1ps
// Top level of the range value replace table.
//
//   port group | direction | beat contents
//   in_        | input     | action, first_pos, last_pos, match/replace/load values
//   out_       | output    | read_value, one beat per read item
//   cfg_       | input     | active_length, written whenever cfg_wr_en is high
//
// A read looks up the element and then its remap entry. A load folds the
// 64-element segment through the two memory ports, then resets its 100-entry
// table. A replace runs a remap pass over each segment between the first and
// the last, and a fold plus table reset on the first and the last segment.
// After reset a clearing pass sets every remap table to identity; in_ready stays
// low meanwhile. A read result waits in the output register while the next beat is taken.
module range_value_replace_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rvrt_pkg::ACT_W-1:0]  in_action,
  input  logic [rvrt_pkg::POS_W-1:0]  in_first_pos,
  input  logic [rvrt_pkg::POS_W-1:0]  in_last_pos,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_match_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_replace_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_load_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rvrt_pkg::VAL_W-1:0]  out_read_value,
  input  logic                        cfg_wr_en,
  input  logic [rvrt_pkg::POS_W-1:0]  cfg_wr_data
);
  import rvrt_pkg::*;

  elem_req_t        elem_req;
  remap_req_t       remap_req;
  logic [VAL_W-1:0] elem_rdata;
  logic [VAL_W-1:0] remap_rdata;

  rvrt_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_first_pos     (in_first_pos),
    .in_last_pos      (in_last_pos),
    .in_match_value   (in_match_value),
    .in_replace_value (in_replace_value),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .elem_req         (elem_req),
    .elem_rdata       (elem_rdata),
    .remap_req        (remap_req),
    .remap_rdata      (remap_rdata)
  );

  rvrt_elem_mem u_elem_mem (
    .clk   (clk),
    .req   (elem_req),
    .rdata (elem_rdata)
  );

  rvrt_remap_mem u_remap_mem (
    .clk   (clk),
    .req   (remap_req),
    .rdata (remap_rdata)
  );

endmodule

// ===== tb/sv/rvrt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the range value replace table: watches beats, predicts read values, compares.
module rvrt_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [rvrt_pkg::ACT_W-1:0]  in_action,
  input  logic [rvrt_pkg::POS_W-1:0]  in_first_pos,
  input  logic [rvrt_pkg::POS_W-1:0]  in_last_pos,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_match_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_replace_value,
  input  logic [rvrt_pkg::VAL_W-1:0]  in_load_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [rvrt_pkg::VAL_W-1:0]  out_read_value,
  input  logic                        cfg_wr_en,
  input  logic [rvrt_pkg::POS_W-1:0]  cfg_wr_data,
  output int                          fail_count,
  output int                          reads_pending,
  output int                          reads_checked
);
  import rvrt_pkg::*;

  localparam int SEGS = SEG_COUNT;

  logic [VAL_W-1:0] elem_mirror [ARRAY_DEPTH];
  logic [VAL_W-1:0] remap_mirror [SEGS][VALUE_COUNT];
  int unsigned      active_len;
  logic [VAL_W-1:0] read_values_due [$];

  function automatic int unsigned len_in_use();
    return (active_len > ARRAY_DEPTH) ? ARRAY_DEPTH : active_len;
  endfunction

  function automatic bit legal_value(int unsigned v);
    return (v >= 1) && (v <= VALUE_COUNT);
  endfunction

  function automatic logic [VAL_W-1:0] mapped(int unsigned seg, logic [VAL_W-1:0] v);
    if (legal_value(v)) return remap_mirror[seg][v-1];
    return v;
  endfunction

  function automatic void fold_into_elements(int unsigned seg);
    int unsigned base;
    base = seg * SEGMENT_SIZE;
    for (int unsigned i = base; i < base + SEGMENT_SIZE && i < ARRAY_DEPTH; i++)
      elem_mirror[i] = mapped(seg, elem_mirror[i]);
    for (int j = 0; j < VALUE_COUNT; j++) remap_mirror[seg][j] = VAL_W'(j + 1);
  endfunction

  function automatic void edit_elements(int unsigned lo, int unsigned hi,
                                        logic [VAL_W-1:0] m, logic [VAL_W-1:0] r);
    for (int unsigned p = lo; p <= hi; p++)
      if (elem_mirror[p-1] == m) elem_mirror[p-1] = r;
  endfunction

  function automatic void apply_replace(int unsigned first, int unsigned last,
                                        logic [VAL_W-1:0] m, logic [VAL_W-1:0] r);
    int unsigned segl, segr;
    if (last > len_in_use()) last = len_in_use();
    if (first == 0 || first > last) return;
    if (!legal_value(m) || !legal_value(r)) return;
    segl = (first - 1) / SEGMENT_SIZE;
    segr = (last - 1) / SEGMENT_SIZE;
    if (segl == segr) begin
      fold_into_elements(segl);
      edit_elements(first, last, m, r);
      return;
    end
    for (int unsigned s = segl + 1; s < segr; s++)
      for (int j = 0; j < VALUE_COUNT; j++)
        if (remap_mirror[s][j] == m) remap_mirror[s][j] = r;
    fold_into_elements(segl);
    edit_elements(first, (segl + 1) * SEGMENT_SIZE, m, r);
    fold_into_elements(segr);
    edit_elements(segr * SEGMENT_SIZE + 1, last, m, r);
  endfunction

  function automatic void apply_beat(logic [ACT_W-1:0] act, int unsigned first,
                                     int unsigned last, logic [VAL_W-1:0] m,
                                     logic [VAL_W-1:0] r, logic [VAL_W-1:0] lv);
    bit          pos_ok;
    int unsigned seg;
    pos_ok = (first >= 1) && (first <= len_in_use());
    seg = pos_ok ? (first - 1) / SEGMENT_SIZE : 0;
    case (act)
      ACT_LOAD: begin
        if (pos_ok && legal_value(lv)) begin
          fold_into_elements(seg);
          elem_mirror[first-1] = lv;
        end
      end
      ACT_REPLACE: apply_replace(first, last, m, r);
      ACT_READ: read_values_due.push_back(pos_ok ? mapped(seg, elem_mirror[first-1]) : '0);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    reads_checked = 0;
    reads_pending = 0;
  end

  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < ARRAY_DEPTH; i++) elem_mirror[i] = '0;
      for (int s = 0; s < SEGS; s++)
        for (int j = 0; j < VALUE_COUNT; j++) remap_mirror[s][j] = VAL_W'(j + 1);
      active_len = 0;
      read_values_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (read_values_due.size() == 0) begin
          report_mismatch($sformatf("read beat %0d with none due", out_read_value));
        end else begin
          want = read_values_due.pop_front();
          reads_checked++;
          if (out_read_value !== want)
            report_mismatch($sformatf("read_value %0d, want %0d", out_read_value, want));
        end
      end
      if (in_valid && in_ready)
        apply_beat(in_action, in_first_pos, in_last_pos, in_match_value,
                   in_replace_value, in_load_value);
      if (cfg_wr_en) active_len = cfg_wr_data;
    end
    reads_pending = read_values_due.size();
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, stall patterns and the verdict.
module testbench;
  import rvrt_pkg::*;

  localparam int IDLE_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 7000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   in_action = ACT_LOAD;
  logic [POS_W-1:0]   in_first_pos = '0;
  logic [POS_W-1:0]   in_last_pos = '0;
  logic [VAL_W-1:0]   in_match_value = '0;
  logic [VAL_W-1:0]   in_replace_value = '0;
  logic [VAL_W-1:0]   in_load_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VAL_W-1:0]   out_read_value;
  logic               cfg_wr_en = 1'b0;
  logic [POS_W-1:0]   cfg_wr_data = '0;
  int                 fail_count, reads_pending, reads_checked;

  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 items_sent = 0;
  int unsigned        cur_len = 0;
  bit                 loaded [ARRAY_DEPTH+1];
  int unsigned        loaded_list [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_value_replace_table dut (.*);

  rvrt_checker u_checker (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("range_value_replace_table test failed");
      $finish;
    end
  end

  // receiver: stall pattern switching between free, patchy and sparse modes
  always @(negedge clk) begin
    static int mode = 0;
    static int mode_left = 0;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_beat(logic [ACT_W-1:0] act, int unsigned first, int unsigned last,
                           int unsigned m, int unsigned r, int unsigned lv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_action = act;
    in_first_pos = POS_W'(first);
    in_last_pos = POS_W'(last);
    in_match_value = VAL_W'(m);
    in_replace_value = VAL_W'(r);
    in_load_value = VAL_W'(lv);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (act == ACT_LOAD && first >= 1 && first <= cur_len && first <= ARRAY_DEPTH &&
        lv >= 1 && lv <= VALUE_COUNT && !loaded[first]) begin
      loaded[first] = 1'b1;
      loaded_list.push_back(first);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (reads_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(int unsigned len);
    settle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = POS_W'(len);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_len = len;
  endtask

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(101, 127);
      2:       return 100;
      3, 4:    return $urandom_range(1, 100);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int unsigned used_len();
    return (cur_len > ARRAY_DEPTH) ? ARRAY_DEPTH : cur_len;
  endfunction

  function automatic int unsigned pick_pos();
    if (used_len() == 0 || $urandom_range(0, 19) == 0)
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(used_len() + 1, 8191);
    return $urandom_range(1, used_len());
  endfunction

  task automatic random_item();
    int unsigned first, last, span, pos;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      send_beat(ACT_LOAD, pick_pos(), $urandom_range(0, 8191), pick_value(),
                pick_value(), pick_value());
    end else if (roll < 65) begin
      first = pick_pos();
      case ($urandom_range(0, 29))
        0:       last = $urandom_range(0, 8191);
        1:       begin first = 1; last = 8191; end
        2:       last = (first > 1) ? $urandom_range(0, first - 1) : 0;
        default: begin
          span = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 40);
          last = first + span;
        end
      endcase
      send_beat(ACT_REPLACE, first, last & 13'h1fff, pick_value(), pick_value(),
                $urandom_range(0, 127));
    end else if (roll < 97) begin
      pos = 0;
      if (loaded_list.size() != 0 && $urandom_range(0, 9) != 0) begin
        pos = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        if (pos > used_len()) pos = 0;
      end
      if (pos == 0 && $urandom_range(0, 1) == 1 && used_len() < 8191)
        pos = $urandom_range(used_len() + 1, 8191);
      if (pos != 0 && pos <= used_len() && !loaded[pos]) pos = 0;
      send_beat(ACT_READ, pos, $urandom_range(0, 8191), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom_range(0, 127));
    end else begin
      send_beat(2'd3, $urandom_range(0, 8191), $urandom_range(0, 8191),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
    end
  endtask

  initial begin
    int unsigned lengths [7] = '{4096, 1, 130, 8191, 0, 200, 4096};
    int          counts  [7] = '{320, 40, 200, 200, 20, 150, 170};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    while (!in_ready) @(negedge clk);
    set_length(4096);

    send_beat(ACT_LOAD, 1, 0, 0, 0, 1);
    send_beat(ACT_LOAD, 4096, 0, 0, 0, 100);
    send_beat(ACT_LOAD, 64, 0, 0, 0, 1);
    send_beat(ACT_LOAD, 65, 0, 0, 0, 1);
    send_beat(ACT_LOAD, 2000, 0, 0, 0, 1);
    send_beat(ACT_LOAD, 2, 0, 0, 0, 0);
    send_beat(ACT_LOAD, 3, 0, 0, 0, 127);
    send_beat(ACT_READ, 1, 0, 0, 0, 0);
    send_beat(ACT_READ, 4096, 0, 0, 0, 0);
    send_beat(ACT_REPLACE, 1, 8191, 1, 100, 0);
    send_beat(ACT_READ, 2000, 0, 0, 0, 0);
    send_beat(ACT_READ, 65, 0, 0, 0, 0);
    send_beat(ACT_REPLACE, 2, 65, 100, 7, 0);
    send_beat(ACT_READ, 64, 0, 0, 0, 0);
    send_beat(ACT_LOAD, 2000, 0, 0, 0, 42);
    send_beat(ACT_READ, 2000, 0, 0, 0, 0);
    send_beat(ACT_REPLACE, 1, 4096, 0, 5, 0);
    send_beat(ACT_REPLACE, 1, 4096, 100, 101, 0);
    send_beat(ACT_REPLACE, 100, 50, 7, 9, 0);
    send_beat(ACT_REPLACE, 0, 100, 7, 9, 0);
    send_beat(2'd3, 8191, 8191, 127, 127, 127);
    send_beat(ACT_READ, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 8191, 8191, 127, 127, 127);

    foreach (lengths[p]) begin
      set_length(lengths[p]);
      repeat (counts[p]) random_item();
    end

    settle();
    $display("%0d beats sent over %0d active lengths, %0d reads checked",
             items_sent, $size(lengths), reads_checked);
    if (fail_count == 0 && reads_pending == 0) begin
      $display("range_value_replace_table test passed");
    end else begin
      $display("%0d mismatches, %0d reads outstanding", fail_count, reads_pending);
      $display("range_value_replace_table test failed");
    end
    $finish;
  end
endmodule
